// File: design/ncps_pkg.sv
// Shared types and constants for the nearest color pixel search block.
package ncps_pkg;

    localparam int CHAN_W      = 8;
    localparam int COORD_W     = 8;
    localparam int DIST_W      = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int RES_DEPTH   = 2;

    localparam logic [DIST_W-1:0]  DIST_NONE     = '1;
    localparam logic [CHAN_W-1:0]  TOL_RESET     = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RED   = 2'd0,
        CFG_TARGET_GREEN = 2'd1,
        CFG_TARGET_BLUE  = 2'd2,
        CFG_TOLERANCE    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] tol;
    } color_cfg_t;

    // One classified pixel handed from the front to the back.
    typedef struct packed {
        logic               hit;
        logic [DIST_W-1:0]  dist_sq;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } pix_item_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [DIST_W-1:0]  dist_sq;
    } search_result_t;

endpackage

// File: design/ncps_front.sv
// Front end: color match test and squared distance to the center, two stages.
module ncps_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ncps_pkg::color_cfg_t                  cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ncps_pkg::CHAN_W-1:0]           pixel_red,
    input  logic [ncps_pkg::CHAN_W-1:0]           pixel_green,
    input  logic [ncps_pkg::CHAN_W-1:0]           pixel_blue,
    input  logic [ncps_pkg::COORD_W-1:0]          pixel_col,
    input  logic [ncps_pkg::COORD_W-1:0]          pixel_row,
    input  logic [ncps_pkg::COORD_W-1:0]          center_col,
    input  logic [ncps_pkg::COORD_W-1:0]          center_row,
    input  logic                                  frame_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ncps_pkg::pix_item_t                   out_item
);

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // stage 1: channel compare and coordinate offsets
    logic                             s1_valid_reg, s1_valid_next;
    logic                             s1_hit_reg;
    logic [ncps_pkg::COORD_W-1:0]     s1_dx_reg, s1_dy_reg;
    logic [ncps_pkg::COORD_W-1:0]     s1_col_reg, s1_row_reg;
    logic                             s1_last_reg;
    // stage 2: squared distance
    logic                             s2_valid_reg, s2_valid_next;
    ncps_pkg::pix_item_t              s2_item_reg;

    logic                             s1_free, s2_free;
    logic                             hit;
    logic [15:0]                      dx_sq, dy_sq;

    assign s2_free  = !s2_valid_reg || out_ready;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    assign hit = (abs_diff(pixel_red,   cfg.red)   <= cfg.tol) &&
                 (abs_diff(pixel_green, cfg.green) <= cfg.tol) &&
                 (abs_diff(pixel_blue,  cfg.blue)  <= cfg.tol);

    assign dx_sq = 16'(s1_dx_reg) * 16'(s1_dx_reg);
    assign dy_sq = 16'(s1_dy_reg) * 16'(s1_dy_reg);

    always_comb
    begin
        s1_valid_next = s1_free ? in_valid : s1_valid_reg;
        s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            s1_hit_reg  <= hit;
            s1_dx_reg   <= abs_diff(pixel_col, center_col);
            s1_dy_reg   <= abs_diff(pixel_row, center_row);
            s1_col_reg  <= pixel_col;
            s1_row_reg  <= pixel_row;
            s1_last_reg <= frame_end;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_item_reg.hit     <= s1_hit_reg;
            s2_item_reg.dist_sq <= 17'(dx_sq) + 17'(dy_sq);
            s2_item_reg.col     <= s1_col_reg;
            s2_item_reg.row     <= s1_row_reg;
            s2_item_reg.last    <= s1_last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

// File: design/ncps_queue.sv
// Short FIFO of classified pixels between the front and the back.
module ncps_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ncps_pkg::pix_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ncps_pkg::pix_item_t  out_item
);

    localparam int PTR_W = $clog2(ncps_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ncps_pkg::QUEUE_DEPTH + 1);

    ncps_pkg::pix_item_t     entry_reg [ncps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    push, pop;

    assign in_ready  = (count_reg != CNT_W'(ncps_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: design/ncps_back.sv
// Back end: nearest-match tracking and a small result buffer.
module ncps_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ncps_pkg::pix_item_t                  in_item,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output ncps_pkg::search_result_t             res_data
);

    localparam int RPTR_W = $clog2(ncps_pkg::RES_DEPTH);
    localparam int RCNT_W = $clog2(ncps_pkg::RES_DEPTH + 1);

    logic [ncps_pkg::COORD_W-1:0]  best_col_reg, best_col_next;
    logic [ncps_pkg::COORD_W-1:0]  best_row_reg, best_row_next;
    logic [ncps_pkg::DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic                          any_match_reg, any_match_next;

    ncps_pkg::search_result_t      res_reg [ncps_pkg::RES_DEPTH];
    logic [RPTR_W-1:0]             res_wr_reg, res_wr_next;
    logic [RPTR_W-1:0]             res_rd_reg, res_rd_next;
    logic [RCNT_W-1:0]             res_cnt_reg, res_cnt_next;

    logic                          res_full, take, better, res_push, res_pop;
    ncps_pkg::search_result_t      new_res;

    assign res_full  = (res_cnt_reg == RCNT_W'(ncps_pkg::RES_DEPTH));
    // A frame's last pixel needs room in the result buffer; others never stall.
    assign in_ready  = !in_item.last || !res_full;
    assign take      = in_valid && in_ready;
    assign better    = in_item.hit && (in_item.dist_sq < best_dist_reg);
    assign res_push  = take && in_item.last;
    assign res_valid = (res_cnt_reg != '0);
    assign res_pop   = res_valid && res_ready;
    assign res_data  = res_reg[res_rd_reg];

    always_comb
    begin
        new_res.found   = any_match_reg || better;
        new_res.col     = better ? in_item.col     : best_col_reg;
        new_res.row     = better ? in_item.row     : best_row_reg;
        new_res.dist_sq = better ? in_item.dist_sq : best_dist_reg;

        best_col_next  = best_col_reg;
        best_row_next  = best_row_reg;
        best_dist_next = best_dist_reg;
        any_match_next = any_match_reg;
        if (take)
        begin
            if (in_item.last)
            begin
                best_col_next  = '0;
                best_row_next  = '0;
                best_dist_next = ncps_pkg::DIST_NONE;
                any_match_next = 1'b0;
            end
            else
            begin
                best_col_next  = new_res.col;
                best_row_next  = new_res.row;
                best_dist_next = new_res.dist_sq;
                any_match_next = new_res.found;
            end
        end

        res_wr_next  = res_push ? res_wr_reg + 1'b1 : res_wr_reg;
        res_rd_next  = res_pop  ? res_rd_reg + 1'b1 : res_rd_reg;
        res_cnt_next = res_cnt_reg + RCNT_W'(res_push) - RCNT_W'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            best_dist_reg <= ncps_pkg::DIST_NONE;
            any_match_reg <= 1'b0;
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_cnt_reg   <= '0;
        end
        else
        begin
            best_col_reg  <= best_col_next;
            best_row_reg  <= best_row_next;
            best_dist_reg <= best_dist_next;
            any_match_reg <= any_match_next;
            res_wr_reg    <= res_wr_next;
            res_rd_reg    <= res_rd_next;
            res_cnt_reg   <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg[res_wr_reg] <= new_res;
        end
    end

endmodule

// File: design/nearest_color_pixel_search.sv
// Top level of the nearest color pixel search block.
//
// Pixels of a search window stream in on the slave side, one word per clock
// while s_axis_tready is high, in raster order; tlast marks the window's final
// pixel. A pixel matches when each of its red, green and blue values lies
// within match_tolerance of the target color. Among matching pixels the block
// keeps the one nearest (by squared distance) to the center point sent with
// each pixel; on a tie the earlier pixel wins. After the final pixel one word
// leaves on the master side: tuser is the found flag, tdata the winner's
// column, row and squared distance (column 0, row 0 and distance 131071 when
// nothing matched). Throughput is one pixel per clock unless a final pixel
// waits on a full result buffer long enough to fill the pixel queue. With
// empty queues the final pixel's accepting edge loads the channel compare
// stage, then come the squaring stage, the four-word pixel queue, and the
// tracking stage that writes the result word into a two-word result buffer.
// Only a final pixel ever waits in the back end, and only while both result
// buffer slots are full; the queue lets the front keep accepting until it fills.
// Write configuration only while the block is idle.
module nearest_color_pixel_search (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [ncps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ncps_pkg::CHAN_W-1:0]          cfg_wdata,
    // pixel stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue,
    // [31:24] pixel_col, [39:32] pixel_row, [47:40] center_col, [55:48] center_row
    input  logic [55:0]                          s_axis_tdata,
    input  logic                                 s_axis_tlast,  // frame_end
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] match_col, [15:8] match_row, [32:16] match_dist_sq, [39:33] zero
    output logic [39:0]                          m_axis_tdata,
    output logic                                 m_axis_tuser   // match_found
);

    ncps_pkg::color_cfg_t       cfg_reg, cfg_next;
    logic                       fq_valid, fq_ready;
    ncps_pkg::pix_item_t        fq_item;
    logic                       qb_valid, qb_ready;
    ncps_pkg::pix_item_t        qb_item;
    ncps_pkg::search_result_t   result;

    // Register writes: the index decodes onto one of the four color settings.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (ncps_pkg::cfg_index_t'(cfg_index))
                ncps_pkg::CFG_TARGET_RED:   cfg_next.red   = cfg_wdata;
                ncps_pkg::CFG_TARGET_GREEN: cfg_next.green = cfg_wdata;
                ncps_pkg::CFG_TARGET_BLUE:  cfg_next.blue  = cfg_wdata;
                ncps_pkg::CFG_TOLERANCE:    cfg_next.tol   = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red   <= '0;
            cfg_reg.green <= '0;
            cfg_reg.blue  <= '0;
            cfg_reg.tol   <= ncps_pkg::TOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify each pixel and compute its squared distance.
    ncps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .pixel_red   (s_axis_tdata[7:0]),
        .pixel_green (s_axis_tdata[15:8]),
        .pixel_blue  (s_axis_tdata[23:16]),
        .pixel_col   (s_axis_tdata[31:24]),
        .pixel_row   (s_axis_tdata[39:32]),
        .center_col  (s_axis_tdata[47:40]),
        .center_row  (s_axis_tdata[55:48]),
        .frame_end   (s_axis_tlast),
        .out_valid   (fq_valid),
        .out_ready   (fq_ready),
        .out_item    (fq_item)
    );

    // Queue: decouple the front from a back end stalled on a full result buffer.
    ncps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Back: track the nearest match, emit and clear at the end of each window.
    ncps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (result)
    );

    assign m_axis_tdata = {7'd0, result.dist_sq, result.row, result.col};
    assign m_axis_tuser = result.found;

endmodule
